// ===== rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared constants, codes, types and the key ordering function for the
// binary heap priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  // heap geometry
  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // request codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // heap ram request: write enable, address and data, and two read addresses
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

  // true when key a belongs strictly above key b in the current order
  function automatic logic ranks_above(input key_t a, input key_t b, input logic min_first);
    ranks_above = min_first ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// heap key storage: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ram (
  input  wire logic               clk,
  input  wire bhpq_pkg::ram_req_t req,
  output      bhpq_pkg::key_t     rdata_a,
  output      bhpq_pkg::key_t     rdata_b
);
  import bhpq_pkg::*;

  key_t mem [DEPTH];
  key_t rdata_a_r;
  key_t rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read ports, registered read data
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[req.raddr_a];
    rdata_b_r <= mem[req.raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

// ===== rtl/binary_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// priority queue of up to 64 keys kept as a 0-based binary heap in one ram
// ----------------------------------------------------------------------------
// Each request inserts a key, pops the top key or peeks at it, and returns
// exactly one result with the top key (pop or peek), a status and the count
// held afterwards. One request is worked on at a time. The heap walk runs one
// level per cycle, set by the registered read data of the heap ram in the
// read-compare-write loop; a key moves at most 6 levels for an insert and 5
// for a pop with 64 keys. A finished result waits in the output register
// while the next request is accepted. cfg_data selects the order: 0 keeps the
// largest key on top, 1 the smallest; change it only with the queue idle
// (stored keys are not reordered).
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] key_in
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [31:0] key_out, [38:32] count, [39] zero
  output      logic [1:0]  out_tuser,  // [1:0] status
  // mode register write
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_data
);
  import bhpq_pkg::*;

  localparam int CW = ADDR_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_DOWN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  addr_t            pos_r, pos_nxt;
  key_t             cur_r, cur_nxt;
  logic [1:0]       act_r, act_nxt;
  key_t             res_key_r, res_key_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             min_first_r;
  logic             out_tvalid_r;
  key_t             out_key_r;
  logic [1:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;

  ram_req_t ram_req;
  key_t     rd_a;
  key_t     rd_b;

  logic          in_accept;
  logic          out_load;
  addr_t         par;
  logic [CW-1:0] lc_w, rc_w, child_w, cnt_w;
  logic          sel_l, sel_r;
  key_t          best_key;
  addr_t         child;

  bhpq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // handshakes
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // heap index arithmetic
  assign par     = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  assign lc_w    = {1'b0, pos_r, 1'b1};
  assign rc_w    = lc_w + CW'(1);
  assign cnt_w   = CW'(cnt_r);

  // sift-down selection: left child first, right only when strictly better
  assign sel_l    = (lc_w < cnt_w) && ranks_above(rd_a, cur_r, min_first_r);
  assign best_key = sel_l ? rd_a : cur_r;
  assign sel_r    = (rc_w < cnt_w) && ranks_above(rd_b, best_key, min_first_r);
  assign child_w  = sel_r ? rc_w : lc_w;
  assign child    = child_w[ADDR_W-1:0];

  // request sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    act_nxt        = act_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;
    ram_req.we      = 1'b0;
    ram_req.waddr   = pos_r;
    ram_req.wdata   = cur_r;
    ram_req.raddr_a = '0;
    ram_req.raddr_b = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          act_nxt        = in_tuser;
          res_key_nxt    = '0;
          res_status_nxt = ST_OK;
          priority if (in_tuser == ACT_INSERT) begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              pos_nxt = cnt_r[ADDR_W-1:0];
              cur_nxt = in_tdata[KEY_WIDTH-1:0];
              cnt_nxt = cnt_r + CNT_W'(1);
              if (cnt_r == '0) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = in_tdata[KEY_WIDTH-1:0];
                state_nxt     = S_DONE;
              end else begin
                ram_req.raddr_a = ADDR_W'((cnt_r[ADDR_W-1:0] - ADDR_W'(1)) >> 1);
                state_nxt       = S_UP;
              end
            end
          end else if (in_tuser == ACT_POP || in_tuser == ACT_PEEK) begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              ram_req.raddr_a = '0;
              ram_req.raddr_b = ADDR_W'(cnt_r - CNT_W'(1));
              state_nxt       = S_FETCH;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // root and last key are back from the ram
      S_FETCH: begin
        res_key_nxt = rd_a;
        if (act_r == ACT_POP) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          cur_nxt = rd_b;
          pos_nxt = '0;
          ram_req.raddr_a = ADDR_W'(1);
          ram_req.raddr_b = ADDR_W'(2);
          state_nxt = (cnt_r == CNT_W'(1)) ? S_DONE : S_DOWN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // parent key is back: move the hole up or settle the key
      S_UP: begin
        ram_req.we = 1'b1;
        if (pos_r == '0 || !ranks_above(cur_r, rd_a, min_first_r)) begin
          state_nxt = S_DONE;
        end else begin
          ram_req.wdata   = rd_a;
          pos_nxt         = par;
          ram_req.raddr_a = ADDR_W'((par - ADDR_W'(1)) >> 1);
        end
      end

      // both children are back: move the hole down or settle the key
      S_DOWN: begin
        ram_req.we = 1'b1;
        if (!sel_l && !sel_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_req.wdata   = sel_r ? rd_b : rd_a;
          pos_nxt         = child;
          ram_req.raddr_a = ADDR_W'({child, 1'b1});
          ram_req.raddr_b = ADDR_W'({child, 1'b1} + (ADDR_W + 1)'(1));
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      min_first_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        min_first_r <= cfg_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    act_r        <= act_nxt;
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_key_r    <= res_key_r;
      out_status_r <= res_status_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_count_r, out_key_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count beyond heap depth");

  a_down_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN && ram_req.we) |-> (CNT_W'(ram_req.waddr) < cnt_r))
    else $error("sift-down write outside the held keys");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == ACT_INSERT && cnt_r != CNT_W'(DEPTH))
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the heap");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(DEPTH)))
    else $error("full status with heap not full");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for binary_heap_priority_queue_unit
// drives insert, pop, peek and unused requests through the stream ports,
// keeps its own heap to predict every result and checks each result
// transaction field by field; covers both key orders, empty and full
// queues, equal keys, order changes with keys held and long output stalls
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 500_000;
  localparam int         HOLD_CYCLES = 300;

  typedef struct {
    key_t             key;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } heap_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // [31:0] key_in
  logic [1:0]  in_tuser   = '0;  // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [31:0] key_out, [38:32] count, [39] zero
  logic [1:0]  out_tuser;        // [1:0] status
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = 1'b0;

  // predicted queue contents and order
  key_t heap_keys [DEPTH];
  int   heap_fill       = 0;
  logic order_min_first = 1'b0;

  heap_result_t expected_results [$];
  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  binary_heap_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // strict order test in the current mode
  function automatic logic outranks(input key_t a, input key_t b);
    return order_min_first ? (a < b) : (a > b);
  endfunction

  // apply one request to the predicted heap and return its result
  function automatic heap_result_t predict_request(input logic [1:0] act, input key_t key);
    heap_result_t res;
    int   pos, up, lc, rc, best;
    key_t t;
    res.key    = '0;
    res.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (heap_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = heap_fill;
          heap_keys[pos] = key;
          // sift up
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!outranks(heap_keys[pos], heap_keys[up])) break;
            t = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up] = t;
            pos = up;
          end
          heap_fill++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (heap_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = heap_keys[0];
          if (act == ACT_POP) begin
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            // sift down, left child tried first
            forever begin
              lc = 2 * pos + 1;
              rc = lc + 1;
              best = pos;
              if (lc < heap_fill && outranks(heap_keys[lc], heap_keys[best])) best = lc;
              if (rc < heap_fill && outranks(heap_keys[rc], heap_keys[best])) best = rc;
              if (best == pos) break;
              t = heap_keys[pos];
              heap_keys[pos] = heap_keys[best];
              heap_keys[best] = t;
              pos = best;
            end
          end
        end
      end
      default: ;
    endcase
    res.count = heap_fill[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_tdata[31:0]);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[KEY_WIDTH-1:0] !== want.key)
          report_mismatch("key_out", want.key, out_tdata[KEY_WIDTH-1:0]);
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata[KEY_WIDTH +: CNT_W] !== want.count)
          report_mismatch("count", 32'(want.count), 32'(out_tdata[KEY_WIDTH +: CNT_W]));
      end
    end
  end

  // result receiver, with random stalls and requested long hold-offs
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // send one request transaction, valid stays high for a following one
  task automatic send_request(input logic [1:0] act, input key_t key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_request(act, key));
  endtask

  // drop valid and wait until every result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_order(input logic min_first);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= min_first;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_min_first = min_first;
  endtask

  // mostly extremes and small keys so equal keys are common
  function automatic key_t pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return key_t'($urandom_range(15));
      5:       return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return key_t'($urandom());
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(ACT_PEEK, '1);
    send_request(ACT_POP, '0);
    send_request(ACT_UNUSED, '1);
  endtask

  // largest key on top, with equal keys and extremes
  task automatic test_max_order();
    write_order(1'b0);
    send_request(ACT_INSERT, 32'd5);
    send_request(ACT_INSERT, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'd0);
    send_request(ACT_INSERT, 32'd5);
    send_request(ACT_INSERT, 32'h8000_0000);
    send_request(ACT_PEEK, '0);
    repeat (6) send_request(ACT_POP, '0);
  endtask

  // smallest key on top, then order change with keys held
  task automatic test_min_order();
    write_order(1'b1);
    send_request(ACT_INSERT, 32'd7);
    send_request(ACT_INSERT, 32'd0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'd7);
    send_request(ACT_POP, '0);
    write_order(1'b0);
    send_request(ACT_INSERT, 32'd3);
    repeat (3) send_request(ACT_POP, '0);
  endtask

  // fill past full, then drain past empty
  task automatic test_fill_and_drain(input logic min_first);
    write_order(min_first);
    repeat (DEPTH + 2) send_request(ACT_INSERT, pick_key());
    send_request(ACT_PEEK, '0);
    repeat (DEPTH + 1) send_request(ACT_POP, '0);
  endtask

  // long output stall so the block backs up into its input
  task automatic test_backpressure();
    hold_requests++;
    repeat (40) begin
      if ($urandom_range(99) < 70) send_request(ACT_INSERT, pick_key());
      else send_request(ACT_POP, '0);
    end
  endtask

  // bursts that lean toward filling, balancing or draining the heap
  task automatic test_random_traffic(input int n_items);
    int         sent, burst_len, insert_pct;
    logic [1:0] act;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) write_order(~order_min_first);
      burst_len = $urandom_range(80, 10);
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      repeat (burst_len) begin
        if ($urandom_range(99) < 2) act = ACT_UNUSED;
        else if ($urandom_range(99) < insert_pct) act = ACT_INSERT;
        else if ($urandom_range(3) == 0) act = ACT_PEEK;
        else act = ACT_POP;
        send_request(act, (act == ACT_INSERT) ? pick_key() : key_t'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles less than receiver
    send_idle_pct = 30;
    recv_idle_pct = 67;
    test_empty_queue();
    test_max_order();
    test_min_order();
    test_fill_and_drain(1'b1);
    write_order(1'b0);
    test_random_traffic(500);

    // receiver idles less than sender
    send_idle_pct = 67;
    recv_idle_pct = 30;
    test_backpressure();
    write_order(1'b1);
    test_random_traffic(500);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_and_drain(1'b0);
    test_random_traffic(500);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
